// ===== hw/rtl/cwpc_pkg.sv =====
// Package: payload types, constants and state codes for the wheel position controller.
package cwpc_pkg;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] encoder_delta;
    } t_in_word;

    typedef struct packed {
        logic [1:0] direction;
        logic [9:0] duty;
        logic       settled;
        logic       running;
    } t_out_word;

    localparam int unsigned PwmMax    = 1000;
    localparam int unsigned DeadZone  = 100;
    localparam int unsigned NearBand  = 100;
    localparam int unsigned SettleBand = 40;
    localparam int unsigned IntegWin  = 200;
    localparam int signed   IntegLim  = 5000;

    localparam logic [2:0] REG_TARGET = 3'd0;
    localparam logic [2:0] REG_VLIM   = 3'd1;
    localparam logic [2:0] REG_PKP    = 3'd2;
    localparam logic [2:0] REG_PKI    = 3'd3;
    localparam logic [2:0] REG_PKD    = 3'd4;
    localparam logic [2:0] REG_VKP    = 3'd5;
    localparam logic [2:0] REG_VKI    = 3'd6;
    localparam logic [2:0] REG_VKD    = 3'd7;

    // Multiplier operand width: 32 bit gains times operands up to 48 bits.
    localparam int unsigned MulAW = 32;
    localparam int unsigned MulBW = 56;
    localparam int unsigned MulCW = 6;   // counter over MulBW bits

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_ERR2,
        S_P1, S_P1W,
        S_P2, S_P2W,
        S_P3, S_P3W,
        S_VSET,
        S_V1, S_V1W,
        S_V2, S_V2W,
        S_V3, S_V3W,
        S_ACC,
        S_NEAR, S_NEARW,
        S_DIV, S_DIVW,
        S_OUT,
        S_HOLD
    } t_state;

endpackage

// ===== hw/rtl/cwpc_sermul.sv =====
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
module cwpc_sermul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [cwpc_pkg::MulAW-1:0]     i_a,
    input  logic signed [cwpc_pkg::MulBW-1:0]     i_b,
    output logic                                  o_done,
    output logic signed [cwpc_pkg::MulAW+cwpc_pkg::MulBW-1:0] o_p
);
    import cwpc_pkg::*;

    localparam int unsigned PW = MulAW + MulBW;

    logic                 r_busy;
    logic [MulCW-1:0]     r_cnt;
    logic [MulBW-1:0]     r_b;
    logic signed [PW-1:0] r_a;
    logic signed [PW-1:0] r_p;

    // Multiplier bits taken LSB first; the top bit carries negative weight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_b    <= i_b;
                r_a    <= PW'(i_a);
                r_p    <= '0;
            end else if (r_busy) begin
                if (r_b[0]) begin
                    if (r_cnt == MulCW'(MulBW - 1)) r_p <= r_p - r_a;
                    else                            r_p <= r_p + r_a;
                end
                r_b <= r_b >> 1;
                r_a <= r_a <<< 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MulCW'(MulBW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_p = r_p;
endmodule

// ===== hw/rtl/cwpc_serdiv.sv =====
// Restoring divider by a constant 100: one quotient bit per cycle, sign restored after.
module cwpc_serdiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_num,
    output logic                o_done,
    output logic signed [63:0]  o_quo
);
    import cwpc_pkg::*;

    logic        r_busy;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_q;
    logic [7:0]  r_rem;
    logic [8:0]  w_trial;

    assign w_trial = {r_rem, r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_num[63];
                r_q    <= i_num[63] ? 64'(-i_num) : 64'(i_num);
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                // shift one dividend bit in, subtract when it fits
                if (w_trial >= 9'(NearBand)) begin
                    r_rem <= 8'(w_trial - 9'(NearBand));
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial[7:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

// ===== hw/rtl/cascaded_wheel_position_controller_top.sv =====
// Top level: cascaded position/velocity PID controller for one wheel.
// Usage: write the target and gains over the APB port while idle, send a start
// word (cmd=1) to clear the count and arm, then one tick word per control period.
// A start word or a tick while disarmed produces no output word. An armed tick
// produces one output word. Six gain products run on one bit-serial
// shift-and-add multiplier, each with its start and handoff. When the error
// is under 100 counts, the near-target scale adds one more product and a
// serial divide by 100. Six more steps make up the rest: S_ERR, S_ERR2,
// S_VSET, S_ACC, S_OUT and S_HOLD. The next input word is taken once the
// block is idle again. A finished output word waits in the output register,
// and the block holds its next result until that word has been handed off.
module cascaded_wheel_position_controller_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cwpc_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cwpc_pkg::t_out_word  o_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import cwpc_pkg::*;

    // configuration registers
    logic signed [31:0] r_target, r_pkp, r_pki, r_pkd, r_vkp, r_vki, r_vkd;
    logic [15:0]        r_vlim;

    // controller state
    logic signed [31:0] r_count, r_plast, r_vlast, r_vprev;
    logic signed [13:0] r_integ;
    logic signed [47:0] r_acc;
    logic               r_armed;

    // working registers
    t_state             r_state, n_state;
    logic signed [15:0] r_delta;
    logic signed [31:0] r_err;
    logic [31:0]        r_aerr;
    logic signed [63:0] r_sum;
    logic signed [33:0] r_bias;
    logic signed [63:0] r_drive;
    t_out_word          r_out;
    logic               r_ovalid;

    logic               w_wr;
    logic [2:0]         w_idx;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_vlim   <= '0;
            r_pkp    <= 32'sd22793;
            r_pki    <= 32'sd97;
            r_pkd    <= 32'sd19005;
            r_vkp    <= -32'sd26214;
            r_vki    <= -32'sd2802;
            r_vkd    <= 32'sd13107;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TARGET: r_target <= pwdata;
                REG_VLIM:   r_vlim   <= pwdata[15:0];
                REG_PKP:    r_pkp    <= pwdata;
                REG_PKI:    r_pki    <= pwdata;
                REG_PKD:    r_pkd    <= pwdata;
                REG_VKP:    r_vkp    <= pwdata;
                REG_VKI:    r_vki    <= pwdata;
                REG_VKD:    r_vkd    <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TARGET: prdata = r_target;
            REG_VLIM:   prdata = {16'd0, r_vlim};
            REG_PKP:    prdata = r_pkp;
            REG_PKI:    prdata = r_pki;
            REG_PKD:    prdata = r_pkd;
            REG_VKP:    prdata = r_vkp;
            REG_VKI:    prdata = r_vki;
            REG_VKD:    prdata = r_vkd;
            default:    prdata = '0;
        endcase
    end

    // shared serial multiplier
    logic                          w_mstart, w_mdone;
    logic signed [MulAW-1:0]       w_ma;
    logic signed [MulBW-1:0]       w_mb;
    logic signed [MulAW+MulBW-1:0] w_mp;
    logic signed [63:0]            w_q;   // product / 65536 toward zero

    cwpc_sermul u_mul (
        .i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
        .o_done(w_mdone), .o_p(w_mp)
    );

    // truncate toward zero: add 65535 before shifting when negative
    logic signed [MulAW+MulBW-1:0] w_padj;
    assign w_padj = w_mp + (w_mp[MulAW+MulBW-1] ? (MulAW+MulBW)'(65535)
                                                : (MulAW+MulBW)'(0));
    assign w_q    = 64'(w_padj >>> 16);

    logic               w_dstart, w_ddone;
    logic signed [63:0] w_dq;
    cwpc_serdiv u_div (
        .i_clk, .i_rst_n, .i_start(w_dstart), .i_num(r_drive),
        .o_done(w_ddone), .o_quo(w_dq)
    );

    // load the output register once it is free or being handed off this cycle
    logic w_load;
    assign w_load  = (r_state == S_HOLD) && !(r_ovalid && i_stall);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    logic w_take;
    assign w_take = i_valid && !o_stall;

    // wide combinational helpers for the sums, limits and magnitude
    logic signed [33:0] w_cnt_sum, w_err_full;
    logic signed [15:0] w_integ_sum;
    logic signed [63:0] w_vset_lo, w_vset_hi;
    logic signed [63:0] w_acc_sum;
    logic signed [63:0] w_mag;

    assign w_cnt_sum   = 34'(r_count) + 34'(r_delta);
    assign w_err_full  = 34'(r_target) - 34'(r_count);
    assign w_integ_sum = 16'(r_integ) + 16'(r_err);
    assign w_vset_hi   = 64'($signed({1'b0, r_vlim}));
    assign w_vset_lo   = -w_vset_hi;
    assign w_acc_sum   = 64'(r_acc) + r_sum;
    assign w_mag       = r_drive[63] ? -r_drive : r_drive;

    // mult operand select per state
    always_comb begin
        w_ma = r_pkp;
        w_mb = 56'(r_err);
        unique case (r_state)
            S_P2, S_P2W: begin w_ma = r_pki; w_mb = 56'(r_integ); end
            S_P3, S_P3W: begin w_ma = r_pkd; w_mb = 56'(34'(r_err) - 34'(r_plast)); end
            S_V1, S_V1W: begin w_ma = r_vkp; w_mb = 56'(r_bias - 34'(r_vlast)); end
            S_V2, S_V2W: begin w_ma = r_vki; w_mb = 56'(r_bias); end
            S_V3, S_V3W: begin
                w_ma = r_vkd;
                w_mb = 56'(r_bias - (34'(r_vlast) <<< 1) + 34'(r_vprev));
            end
            S_NEAR, S_NEARW: begin w_ma = $signed(r_aerr); w_mb = 56'(r_acc); end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = (w_take && !i_data.cmd && r_armed) ? S_ERR : S_IDLE;
            S_ERR:   n_state = S_ERR2;
            S_ERR2:  n_state = S_P1;
            S_P1:    n_state = S_P1W;
            S_P1W:   if (w_mdone) n_state = S_P2;
            S_P2:    n_state = S_P2W;
            S_P2W:   if (w_mdone) n_state = S_P3;
            S_P3:    n_state = S_P3W;
            S_P3W:   if (w_mdone) n_state = S_VSET;
            S_VSET:  n_state = S_V1;
            S_V1:    n_state = S_V1W;
            S_V1W:   if (w_mdone) n_state = S_V2;
            S_V2:    n_state = S_V2W;
            S_V2W:   if (w_mdone) n_state = S_V3;
            S_V3:    n_state = S_V3W;
            S_V3W:   if (w_mdone) n_state = S_ACC;
            S_ACC:   n_state = (r_aerr < 32'(NearBand)) ? S_NEAR : S_OUT;
            S_NEAR:  n_state = S_NEARW;
            S_NEARW: if (w_mdone) n_state = S_DIV;
            S_DIV:   n_state = S_DIVW;
            S_DIVW:  if (w_ddone) n_state = S_OUT;
            S_OUT:   n_state = S_HOLD;
            S_HOLD:  n_state = w_load ? S_IDLE : S_HOLD;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_mstart = (r_state == S_P1) || (r_state == S_P2) || (r_state == S_P3) ||
                      (r_state == S_V1) || (r_state == S_V2) || (r_state == S_V3) ||
                      (r_state == S_NEAR);
    assign w_dstart = (r_state == S_DIV);

    // output register: raise on a new result, drop once the word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_armed  <= 1'b0;
            r_count  <= '0;
            r_plast  <= '0;
            r_integ  <= '0;
            r_vlast  <= '0;
            r_vprev  <= '0;
            r_acc    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (w_take) begin
                    if (i_data.cmd) begin
                        r_count <= '0;
                        r_armed <= 1'b1;
                    end
                    r_delta <= i_data.encoder_delta;
                end
                S_ERR: begin
                    // saturate the running count
                    if (w_cnt_sum > 34'sh0_7FFF_FFFF)       r_count <= 32'h7FFF_FFFF;
                    else if (w_cnt_sum < -34'sh0_8000_0000) r_count <= 32'h8000_0000;
                    else                                     r_count <= w_cnt_sum[31:0];
                end
                S_ERR2: begin
                    logic signed [31:0] e;
                    if (w_err_full > 34'sh0_7FFF_FFFF)       e = 32'h7FFF_FFFF;
                    else if (w_err_full < -34'sh0_8000_0000) e = 32'h8000_0000;
                    else                                     e = w_err_full[31:0];
                    r_err  <= e;
                    r_aerr <= e[31] ? 32'(-e) : 32'(e);
                end
                S_P1: begin
                    // integral window, then clamp; a large error clamps by its sign
                    if (r_aerr < 32'(IntegWin)) r_integ <= '0;
                    else if (r_err > 32'sd10000 ||
                             (r_err >= -32'sd10000 && w_integ_sum > 16'sd5000))
                        r_integ <= 14'(IntegLim);
                    else if (r_err < -32'sd10000 || w_integ_sum < -16'sd5000)
                        r_integ <= 14'(-IntegLim);
                    else r_integ <= w_integ_sum[13:0];
                end
                S_P1W: if (w_mdone) r_sum <= w_q;
                S_P2W: if (w_mdone) r_sum <= r_sum + w_q;
                S_P3W: if (w_mdone) r_sum <= r_sum + w_q;
                S_VSET: begin
                    logic signed [63:0] v;
                    r_plast <= r_err;
                    if (r_sum > w_vset_hi)      v = w_vset_hi;
                    else if (r_sum < w_vset_lo) v = w_vset_lo;
                    else                        v = r_sum;
                    r_bias <= 34'(v) - 34'(r_delta);
                end
                S_V1W: if (w_mdone) r_sum <= w_q;
                S_V2W: if (w_mdone) r_sum <= r_sum + w_q;
                S_V3W: if (w_mdone) r_sum <= r_sum + w_q;
                S_ACC: begin
                    if (w_acc_sum > 64'sh0000_7FFF_FFFF_FFFF)
                        r_acc <= 48'h7FFF_FFFF_FFFF;
                    else if (w_acc_sum < -64'sh0000_8000_0000_0000)
                        r_acc <= 48'h8000_0000_0000;
                    else r_acc <= w_acc_sum[47:0];
                    r_vprev <= r_vlast;
                    r_vlast <= r_bias[31:0];
                end
                S_NEAR: r_drive <= 64'(r_acc);
                S_NEARW: if (w_mdone) r_drive <= 64'(w_mp);
                S_DIVW: if (w_ddone) r_drive <= w_dq;
                S_OUT: begin
                    logic signed [63:0] d;
                    d = (r_aerr < 32'(NearBand)) ? r_drive : 64'(r_acc);
                    if (r_aerr < 32'(SettleBand)) d = '0;
                    r_drive <= d;
                end
                S_HOLD: if (w_load) begin
                    r_out.settled   <= (r_aerr < 32'(SettleBand));
                    r_out.running   <= !(r_aerr < 32'(SettleBand));
                    if (r_aerr < 32'(SettleBand)) r_armed <= 1'b0;
                    if (r_drive == '0) begin
                        r_out.direction <= 2'd0;
                        r_out.duty      <= '0;
                    end else begin
                        r_out.direction <= r_drive[63] ? 2'd2 : 2'd1;
                        if (w_mag < 64'(DeadZone))    r_out.duty <= 10'(DeadZone);
                        else if (w_mag > 64'(PwmMax)) r_out.duty <= 10'(PwmMax);
                        else                          r_out.duty <= w_mag[9:0];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== bench/cascaded_wheel_position_controller_top_test.sv =====
// Testbench: random and directed checks of the cascaded wheel position controller.
`timescale 1ns/1ps
module cascaded_wheel_position_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cwpc_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;
    localparam longint CNT_MAX = 64'sd2147483647;
    localparam longint CNT_MIN = -64'sd2147483648;
    localparam longint ACC_MAX = 64'sd140737488355327;
    localparam longint ACC_MIN = -64'sd140737488355328;
    localparam int     SETTLE_WAIT = 600;     // covers one full tick of the block
    localparam longint CYCLE_LIMIT = 6000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_in_word    i_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out_word   o_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cascaded_wheel_position_controller_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Controller registers as the predictor sees them, indexed by register code.
    logic signed [31:0] ctl_reg [8];

    // Predictor state
    longint wheel_count;
    bit     wheel_armed;
    longint pos_prev_err;
    longint pos_integ;
    longint vel_err_1;
    longint vel_err_2;
    longint vel_sum;

    t_out_word expected_words[$];
    int        fail_count = 0;
    longint    cycle_count = 0;

    // Sender pacing and receiver hold-off
    int burst_left = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Q16.16 gain times operand, exact product, truncated toward zero.
    function automatic longint gain_mul(logic signed [31:0] g, longint x);
        logic signed [127:0] p;
        p = g;
        p = p * x;
        p = p / 65536;
        return longint'(p);
    endfunction

    task automatic load_reset_regs();
        ctl_reg[REG_TARGET] = 0;
        ctl_reg[REG_VLIM]   = 0;
        ctl_reg[REG_PKP]    = 22793;
        ctl_reg[REG_PKI]    = 97;
        ctl_reg[REG_PKD]    = 19005;
        ctl_reg[REG_VKP]    = -26214;
        ctl_reg[REG_VKI]    = -2802;
        ctl_reg[REG_VKD]    = 13107;
        wheel_count = 0;
        wheel_armed = 0;
        pos_prev_err = 0;
        pos_integ = 0;
        vel_err_1 = 0;
        vel_err_2 = 0;
        vel_sum = 0;
    endtask

    // Advance the controller model by one word; returns 1 when an output word follows.
    function automatic bit wheel_step(t_in_word w, output t_out_word res);
        longint d, err, aerr, vset, vlim, bias, drive, m;
        res = '0;
        if (w.cmd == CMD_START) begin
            wheel_count = 0;
            wheel_armed = 1;
            return 0;
        end
        if (!wheel_armed) return 0;
        d = w.encoder_delta;
        vlim = longint'({1'b0, ctl_reg[REG_VLIM][15:0]});
        wheel_count = clip(wheel_count + d, CNT_MIN, CNT_MAX);
        err = clip(longint'(ctl_reg[REG_TARGET]) - wheel_count, CNT_MIN, CNT_MAX);
        aerr = absval(err);
        // position loop with windowed integral
        if (aerr < IntegWin) pos_integ = 0;
        else pos_integ = clip(pos_integ + err, -IntegLim, IntegLim);
        vset = gain_mul(ctl_reg[REG_PKP], err) + gain_mul(ctl_reg[REG_PKI], pos_integ)
             + gain_mul(ctl_reg[REG_PKD], err - pos_prev_err);
        pos_prev_err = err;
        vset = clip(vset, -vlim, vlim);
        // incremental velocity loop
        bias = vset - d;
        vel_sum = clip(vel_sum + gain_mul(ctl_reg[REG_VKP], bias - vel_err_1)
                       + gain_mul(ctl_reg[REG_VKI], bias)
                       + gain_mul(ctl_reg[REG_VKD], bias - 2 * vel_err_1 + vel_err_2),
                       ACC_MIN, ACC_MAX);
        vel_err_2 = vel_err_1;
        vel_err_1 = bias;
        drive = vel_sum;
        if (aerr < NearBand) begin
            drive = (aerr * vel_sum) / 100;
            if (aerr < SettleBand) begin
                drive = 0;
                res.settled = 1'b1;
                wheel_armed = 0;
            end
        end
        res.direction = DIR_STOP;
        if (drive != 0) begin
            res.direction = (drive > 0) ? DIR_FWD : DIR_REV;
            m = absval(drive);
            if (m < DeadZone) m = DeadZone;
            if (m > PwmMax) m = PwmMax;
            res.duty = m[9:0];
        end
        res.running = wheel_armed;
        return 1;
    endfunction

    // Output checker: compare each accepted word against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected output word %p", $time, o_data);
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_data.direction !== exp_w.direction) begin
                    $display("%0t: direction exp %0d act %0d", $time,
                             exp_w.direction, o_data.direction);
                    fail_count++;
                end
                if (o_data.duty !== exp_w.duty) begin
                    $display("%0t: duty exp %0d act %0d", $time, exp_w.duty, o_data.duty);
                    fail_count++;
                end
                if (o_data.settled !== exp_w.settled) begin
                    $display("%0t: settled exp %0d act %0d", $time,
                             exp_w.settled, o_data.settled);
                    fail_count++;
                end
                if (o_data.running !== exp_w.running) begin
                    $display("%0t: running exp %0d act %0d", $time,
                             exp_w.running, o_data.running);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: stall on a drifting pattern, or hold off for a long stretch on request.
    always @(posedge i_clk) begin
        int mode;
        mode = int'((cycle_count / 700) % 4);
        if (hold_req && hold_left == 0) begin
            hold_left = 3000;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (mode == 0) begin
            i_stall <= 1'b0;
        end else if (mode == 1) begin
            i_stall <= ($urandom_range(1, 0) == 0);
        end else if (mode == 2) begin
            i_stall <= ($urandom_range(3, 0) != 0);
        end else begin
            i_stall <= ($urandom_range(7, 0) == 0);
        end
    end

    // Offer one word, wait for it to be taken, predict, then maybe idle the line.
    task automatic send_word(logic cmd, logic signed [15:0] delta);
        t_in_word  w;
        t_out_word r;
        int        gap;
        w.cmd = cmd;
        w.encoder_delta = delta;
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        if (wheel_step(w, r)) expected_words.push_back(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(8, 0);
            // most gaps short, a few long enough to land on any phase of a tick
            gap = ($urandom_range(9, 0) == 0) ? $urandom_range(500, 1) : $urandom_range(6, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected word is out and the block is quiet.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ctl_reg[idx] = value;
    endtask

    function automatic logic [31:0] pick_gain(logic signed [31:0] nominal);
        case ($urandom_range(9, 0))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default: return nominal + $signed($urandom_range(8000, 0)) - 4000;
        endcase
    endfunction

    // Pick a delta: mostly steering toward the target, some noise, some full range.
    function automatic logic signed [15:0] pick_delta();
        longint err, step;
        int     sel;
        sel = $urandom_range(9, 0);
        err = longint'(ctl_reg[REG_TARGET]) - wheel_count;
        if (sel < 7) begin
            if (absval(err) < 300) step = err + $signed($urandom_range(120, 0)) - 60;
            else step = err / longint'($urandom_range(6, 2));
            return 16'(clip(step, -32768, 32767));
        end
        if (sel < 9) return 16'($signed($urandom_range(1000, 0)) - 500);
        return 16'($urandom);
    endfunction

    task automatic test_reset_values();
        // reset gains with a zero velocity limit: the position loop has no authority
        send_word(CMD_TICK, 16'sd5);          // disarmed: ignored
        send_word(CMD_START, 16'sd0);
        send_word(CMD_TICK, 16'sd0);          // zero error settles at once
        send_word(CMD_TICK, 16'sd7);          // disarmed again
        wait_idle();
    endtask

    task automatic test_directed();
        reg_write(REG_TARGET, 32'd1000);
        reg_write(REG_VLIM, 32'd300);
        send_word(CMD_START, 16'sd0);
        send_word(CMD_TICK, 16'sh7fff);       // far overshoot
        send_word(CMD_TICK, -16'sh8000);
        send_word(CMD_TICK, 16'sd0);
        send_word(CMD_TICK, 16'sd1);
        send_word(CMD_TICK, -16'sd1);
        send_word(CMD_TICK, 16'sd0);          // count stays at -1: outside the integral window
        send_word(CMD_TICK, 16'sd0);          // not in the near band: unscaled drive
        send_word(CMD_TICK, 16'sd0);
        send_word(CMD_TICK, 16'sd0);          // still far from the target: no settle
        wait_idle();
        // error saturation and extreme gains
        reg_write(REG_TARGET, 32'h7fff_ffff);
        reg_write(REG_VLIM, 32'hffff);
        reg_write(REG_PKP, 32'h7fff_ffff);
        reg_write(REG_PKI, 32'h8000_0000);
        reg_write(REG_PKD, 32'h7fff_ffff);
        reg_write(REG_VKP, 32'h8000_0000);
        reg_write(REG_VKI, 32'h7fff_ffff);
        reg_write(REG_VKD, 32'h8000_0000);
        send_word(CMD_START, 16'sd0);
        send_word(CMD_TICK, -16'sh8000);
        send_word(CMD_TICK, -16'sh8000);
        send_word(CMD_TICK, 16'sh7fff);
        send_word(CMD_START, 16'sd0);         // restart mid-run keeps histories
        send_word(CMD_TICK, 16'sd0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        send_word(CMD_START, 16'sd0);
        repeat (6) send_word(CMD_TICK, pick_delta());
        wait_idle();
    endtask

    task automatic test_random();
        int words;
        int n;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase % 4)
                0: reg_write(REG_TARGET, 32'($signed($urandom_range(6000, 0)) - 3000));
                1: reg_write(REG_TARGET, $urandom);
                2: reg_write(REG_TARGET, (phase % 8 == 2) ? 32'h8000_0000 : 32'h7fff_ffff);
                default: reg_write(REG_TARGET, 32'($signed($urandom_range(400, 0)) - 200));
            endcase
            case ($urandom_range(3, 0))
                0: reg_write(REG_VLIM, 32'd0);
                1: reg_write(REG_VLIM, 32'hffff);
                default: reg_write(REG_VLIM, $urandom_range(2000, 1));
            endcase
            reg_write(REG_PKP, pick_gain(22793));
            reg_write(REG_PKI, pick_gain(97));
            reg_write(REG_PKD, pick_gain(19005));
            reg_write(REG_VKP, pick_gain(-26214));
            reg_write(REG_VKI, pick_gain(-2802));
            reg_write(REG_VKD, pick_gain(13107));
            words = 0;
            while (words < 82) begin
                send_word(CMD_START, 16'($urandom));
                words++;
                n = $urandom_range(40, 8);
                for (int k = 0; k < n; k++) begin
                    // an occasional stray start or ignored tick rides along
                    if ($urandom_range(29, 0) == 0) send_word(CMD_START, 16'($urandom));
                    else if (wheel_armed) send_word(CMD_TICK, pick_delta());
                    else send_word(CMD_TICK, 16'($urandom));
                    words++;
                end
            end
            wait_idle();
        end
    endtask

    initial begin
        load_reset_regs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_backpressure();
        test_random();
        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cwpc_pkg.sv
hw/rtl/cwpc_sermul.sv
hw/rtl/cwpc_serdiv.sv
hw/rtl/cascaded_wheel_position_controller_top.sv
bench/cascaded_wheel_position_controller_top_test.sv
